// ----- rtl/core/clt_pkg.sv -----
// Shared types and constants for the coordinate-list transpose core.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package clt_pkg;

    localparam int ROW_W = 6;    // stored row / column index width
    localparam int DIM_W = 7;    // dimension and result index width
    localparam int VAL_W = 32;   // entry value width
    localparam int CIDX_W = 2;   // configuration register index width

    localparam int DEF_MAX_ENTRIES = 32;
    localparam int DEF_MAX_DIM = 64;

    localparam logic [DIM_W-1:0] ROW_COUNT_RST = 7'd5;
    localparam logic [DIM_W-1:0] COL_COUNT_RST = 7'd6;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_COL_COUNT = 2'd1;

    typedef struct packed {
        logic [DIM_W-1:0] row_count;
        logic [DIM_W-1:0] col_count;
    } t_cfg;

    // classified transaction handed from the front to the back
    typedef struct packed {
        logic              store;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [VAL_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic              is_header;
        logic [DIM_W-1:0]  out_row;
        logic [DIM_W-1:0]  out_col;
        logic [VAL_W-1:0]  out_value;
        logic              overflow;
        logic              last_result;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/clt_front.sv -----
// Front end: accepts input transactions and classifies them into commands.
// Depends on clt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clt_front import clt_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  wire logic               i_in_valid,
    input  wire logic               i_has_entry,
    input  wire logic [ROW_W-1:0]   i_entry_row,
    input  wire logic [ROW_W-1:0]   i_entry_col,
    input  wire logic [VAL_W-1:0]   i_entry_value,
    input  wire logic               i_last_entry,
    input  wire logic               i_q_full,
    output      logic               o_in_stall,
    output      logic               o_push,
    output      t_cmd               o_cmd
);

    logic w_in_range;

    // drop entries whose indexes fall outside the matrix bound
    assign w_in_range = ({1'b0, i_entry_row} < DIM_W'(MAX_DIM))
                     && ({1'b0, i_entry_col} < DIM_W'(MAX_DIM));

    // build the command; transactions with nothing to do are not queued
    always_comb begin
        o_cmd.store = i_has_entry & w_in_range;
        o_cmd.last  = i_last_entry;
        o_cmd.row   = i_entry_row;
        o_cmd.col   = i_entry_col;
        o_cmd.value = i_entry_value;
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full & (o_cmd.store | o_cmd.last);

endmodule

`default_nettype wire

// ----- rtl/core/clt_queue.sv -----
// Two-entry command queue between the front and back ends.
// Depends on clt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clt_queue import clt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output      logic o_full,
    output      logic o_not_empty,
    output      t_cmd o_head
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    assign o_full      = r_fill[1];
    assign o_not_empty = (r_fill != 2'd0);
    assign o_head      = r_slot[r_rd_ptr];

    // advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    // hold payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/clt_back.sv -----
// Back end: entry store, counting pass, header and column sweep, output register.
// Depends on clt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clt_back import clt_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_DIM     = DEF_MAX_DIM
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire logic    i_q_not_empty,
    input  wire t_cmd    i_q_head,
    output      logic    o_pop,
    input  wire logic    i_out_stall,
    output      logic    o_out_valid,
    output      t_result o_result
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CNT_RD = 6'b000010,
        S_CNT_EV = 6'b000100,
        S_HDR    = 6'b001000,
        S_SWP_RD = 6'b010000,
        S_SWP_EV = 6'b100000
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_entry;

    t_entry            r_mem [MAX_ENTRIES];
    t_entry            r_rd;
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf, n_ovf;
    logic [CW-1:0]     r_hits, n_hits;
    logic [CW-1:0]     r_emit, n_emit;
    logic [AW-1:0]     r_idx, n_idx;
    logic [DIM_W-1:0]  r_col_j, n_col_j;
    logic              r_out_valid;
    t_result           r_out;

    logic              w_wr;
    logic              w_rd;
    logic              w_slot_free;
    logic              w_load;
    t_result           w_res;
    logic [DIM_W-1:0]  w_sweep;
    logic              w_last_idx;
    logic              w_match;

    assign w_slot_free = ~r_out_valid | ~i_out_stall;
    assign w_sweep     = (i_cfg.col_count < DIM_W'(MAX_DIM)) ? i_cfg.col_count
                                                             : DIM_W'(MAX_DIM);
    assign w_last_idx  = ((CW'(r_idx) + CW'(1)) == r_count);
    assign w_match     = ({1'b0, r_rd.col} == r_col_j);
    assign w_rd        = (r_state == S_CNT_RD) || (r_state == S_SWP_RD);
    assign o_pop       = (r_state == S_IDLE) && i_q_not_empty;

    // sequence stores, counting pass, header and sweep
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_hits  = r_hits;
        n_emit  = r_emit;
        n_idx   = r_idx;
        n_col_j = r_col_j;
        w_wr    = 1'b0;
        w_load  = 1'b0;
        w_res   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_not_empty) begin
                    if (i_q_head.store) begin
                        if (r_count < CW'(MAX_ENTRIES)) begin
                            w_wr    = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (i_q_head.last) begin
                        n_hits  = '0;
                        n_emit  = '0;
                        n_idx   = '0;
                        n_col_j = '0;
                        n_state = (n_count == '0) ? S_HDR : S_CNT_RD;
                    end
                end
            end
            S_CNT_RD: begin
                n_state = S_CNT_EV;
            end
            S_CNT_EV: begin
                if ({1'b0, r_rd.col} < w_sweep) begin
                    n_hits = r_hits + CW'(1);
                end
                if (w_last_idx) begin
                    n_idx   = '0;
                    n_state = S_HDR;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_CNT_RD;
                end
            end
            S_HDR: begin
                if (w_slot_free) begin
                    w_load            = 1'b1;
                    w_res.is_header   = 1'b1;
                    w_res.out_row     = i_cfg.col_count;
                    w_res.out_col     = i_cfg.row_count;
                    w_res.out_value   = VAL_W'(r_count);
                    w_res.overflow    = r_ovf;
                    w_res.last_result = (r_hits == '0);
                    if (r_hits == '0) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SWP_RD;
                    end
                end
            end
            S_SWP_RD: begin
                n_state = S_SWP_EV;
            end
            S_SWP_EV: begin
                if (!w_match || w_slot_free) begin
                    if (w_match) begin
                        w_load            = 1'b1;
                        w_res.is_header   = 1'b0;
                        w_res.out_row     = r_col_j;
                        w_res.out_col     = {1'b0, r_rd.row};
                        w_res.out_value   = r_rd.value;
                        w_res.overflow    = r_ovf;
                        w_res.last_result = ((r_emit + CW'(1)) == r_hits);
                        n_emit            = r_emit + CW'(1);
                    end
                    if (w_match && ((r_emit + CW'(1)) == r_hits)) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else if (w_last_idx) begin
                        n_idx   = '0;
                        n_col_j = r_col_j + DIM_W'(1);
                        n_state = S_SWP_RD;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_SWP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_hits      <= '0;
            r_emit      <= '0;
            r_idx       <= '0;
            r_col_j     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_hits  <= n_hits;
            r_emit  <= n_emit;
            r_idx   <= n_idx;
            r_col_j <= n_col_j;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result while stalled
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    // entry store: write at the fill count, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_count[AW-1:0]] <= '{row: i_q_head.row, col: i_q_head.col,
                                        value: i_q_head.value};
        end
        if (w_rd) begin
            r_rd <= r_mem[r_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/coordinate_list_transpose_core.sv -----
// Coordinate-list sparse matrix transpose: top level with configuration registers.
// Depends on clt_pkg, clt_front, clt_queue and clt_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one triplet per transaction.
//   Transactions with i_has_entry set and indexes below MAX_DIM are stored in arrival order;
//   the one with i_last_entry set starts the transpose. Output channel (o_out_valid /
//   i_out_stall) first gives a header (col_count, row_count, stored count),
//   then every stored entry with column below col_count as (col, row, value),
//   ordered by column and then by arrival. o_last_result marks the end.
// Throughput: entry transactions are taken one per cycle through a two-entry
//   command queue, as long as the back end is not busy with a transpose.
// Sequence: after the last transaction the back end makes a counting pass over
//   the N stored entries (a single-port memory read state, then a compare state,
//   for each), emits the header, then scans all N entries for each column
//   until the final match. Input is stalled once the queue fills.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 row_count, 1 col_count); other indexes are ignored. Write only when idle.
// Reset: synchronous active low; clears entry count, overflow flag and queue,
//   and sets row_count 5, col_count 6. Stored entries are not cleared.
// Receiver stall: the result register holds; the header waits, and the sweep waits on a match.
`timescale 1ns / 1ps
`default_nettype none

module coordinate_list_transpose_core import clt_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_DIM     = DEF_MAX_DIM
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CIDX_W-1:0]        i_cfg_index,
    input  wire logic [DIM_W-1:0]         i_cfg_data,
    input  wire logic                     i_in_valid,
    output      logic                     o_in_stall,
    input  wire logic                     i_has_entry,
    input  wire logic [ROW_W-1:0]         i_entry_row,
    input  wire logic [ROW_W-1:0]         i_entry_col,
    input  wire logic signed [VAL_W-1:0]  i_entry_value,
    input  wire logic                     i_last_entry,
    output      logic                     o_out_valid,
    input  wire logic                     i_out_stall,
    output      logic                     o_is_header,
    output      logic [DIM_W-1:0]         o_out_row,
    output      logic [DIM_W-1:0]         o_out_col,
    output      logic signed [VAL_W-1:0]  o_out_value,
    output      logic                     o_overflow,
    output      logic                     o_last_result
);

    t_cfg    r_cfg;
    logic    w_q_full;
    logic    w_push;
    t_cmd    w_cmd;
    logic    w_pop;
    logic    w_q_not_empty;
    t_cmd    w_q_head;
    t_result w_result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_count <= ROW_COUNT_RST;
            r_cfg.col_count <= COL_COUNT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ROW_COUNT) begin
                r_cfg.row_count <= i_cfg_data;
            end else if (i_cfg_index == CFG_COL_COUNT) begin
                r_cfg.col_count <= i_cfg_data;
            end
        end
    end

    clt_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .i_has_entry   (i_has_entry),
        .i_entry_row   (i_entry_row),
        .i_entry_col   (i_entry_col),
        .i_entry_value (i_entry_value),
        .i_last_entry  (i_last_entry),
        .i_q_full      (w_q_full),
        .o_in_stall    (o_in_stall),
        .o_push        (w_push),
        .o_cmd         (w_cmd)
    );

    clt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_cmd       (w_cmd),
        .i_pop       (w_pop),
        .o_full      (w_q_full),
        .o_not_empty (w_q_not_empty),
        .o_head      (w_q_head)
    );

    clt_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_DIM     (MAX_DIM)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_not_empty (w_q_not_empty),
        .i_q_head      (w_q_head),
        .o_pop         (w_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_result      (w_result)
    );

    assign o_is_header   = w_result.is_header;
    assign o_out_row     = w_result.out_row;
    assign o_out_col     = w_result.out_col;
    assign o_out_value   = w_result.out_value;
    assign o_overflow    = w_result.overflow;
    assign o_last_result = w_result.last_result;

endmodule

`default_nettype wire

// ----- verif/tb_coordinate_list_transpose_core.sv -----
// Self-checking bench for coordinate_list_transpose_core: directed triplet lists, then random
// lists under random idling, checked against an in-bench transpose predictor. Depends on clt_pkg.
`timescale 1ns / 1ps

module tb_coordinate_list_transpose_core;
    import clt_pkg::*;

    localparam int IDLE_PCT       = 19;
    localparam int RANDOM_ITEMS   = 395;
    localparam int CALM_FIRST     = 150;
    localparam int CALM_LAST      = 240;
    // longest quiet stretch of a correct run: a full sweep of every column over a full store
    localparam int SETTLE_CYCLES  = 2 * DEF_MAX_ENTRIES * DEF_MAX_DIM + 16;
    localparam int WATCHDOG_LIMIT = 5 * SETTLE_CYCLES + 1000;

    // register indexes past the end of the list; writes to them must be ignored
    localparam logic [CIDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic {STEP_ITEM, STEP_WRITE} t_step_kind;

    typedef struct {
        t_step_kind         kind;
        logic               has;
        logic [ROW_W-1:0]   row;
        logic [ROW_W-1:0]   col;
        logic [VAL_W-1:0]   value;
        logic               last;
        logic [CIDX_W-1:0]  reg_index;
        logic [DIM_W-1:0]   reg_data;
        logic               hdr_given;
        t_result            hdr;
    } t_step;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CIDX_W-1:0]        cfg_index = '0;
    logic [DIM_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     in_has = 1'b0;
    logic [ROW_W-1:0]         in_row = '0;
    logic [ROW_W-1:0]         in_col = '0;
    logic signed [VAL_W-1:0]  in_value = '0;
    logic                     in_last = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     out_is_header;
    logic [DIM_W-1:0]         out_row;
    logic [DIM_W-1:0]         out_col;
    logic signed [VAL_W-1:0]  out_value;
    logic                     out_overflow;
    logic                     out_last;

    // predictor state: stored triplets, count, drop flag and register copies
    logic [ROW_W-1:0]  held_rows [DEF_MAX_ENTRIES];
    logic [ROW_W-1:0]  held_cols [DEF_MAX_ENTRIES];
    logic [VAL_W-1:0]  held_vals [DEF_MAX_ENTRIES];
    int                held_count = 0;
    logic              dropped_flag = 1'b0;
    logic [DIM_W-1:0]  row_count_q = ROW_COUNT_RST;
    logic [DIM_W-1:0]  col_count_q = COL_COUNT_RST;

    t_result  transposed_q [$];
    t_step    directed [$];
    logic     given_hdr_valid = 1'b0;
    t_result  given_hdr = '0;
    logic     calm = 1'b0;
    logic     dirty = 1'b0;
    int       error_count = 0;
    int       items_driven = 0;
    int       results_checked = 0;
    int       lists_done = 0;
    int       overflow_lists = 0;
    int       quiet_cycles = 0;

    coordinate_list_transpose_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_has_entry   (in_has),
        .i_entry_row   (in_row),
        .i_entry_col   (in_col),
        .i_entry_value (in_value),
        .i_last_entry  (in_last),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_is_header   (out_is_header),
        .o_out_row     (out_row),
        .o_out_col     (out_col),
        .o_out_value   (out_value),
        .o_overflow    (out_overflow),
        .o_last_result (out_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Store one triplet; on the last mark, queue the header and the column-ordered sweep
    task automatic predict_transpose(input logic has, input logic [ROW_W-1:0] row,
                                     input logic [ROW_W-1:0] col, input logic [VAL_W-1:0] value,
                                     input logic last);
        int      sweep;
        int      hits;
        int      k;
        t_result r;
        if (has) begin
            if (held_count < DEF_MAX_ENTRIES) begin
                held_rows[held_count] = row;
                held_cols[held_count] = col;
                held_vals[held_count] = value;
                held_count++;
            end else begin
                dropped_flag = 1'b1;
            end
        end
        if (last) begin
            sweep = (col_count_q < DEF_MAX_DIM) ? int'(col_count_q) : DEF_MAX_DIM;
            hits = 0;
            for (int i = 0; i < held_count; i++)
                if (held_cols[i] < sweep) hits++;
            r.is_header   = 1'b1;
            r.out_row     = col_count_q;
            r.out_col     = row_count_q;
            r.out_value   = VAL_W'(held_count);
            r.overflow    = dropped_flag;
            r.last_result = (hits == 0);
            transposed_q.push_back(r);
            k = 1;
            for (int j = 0; j < sweep; j++) begin
                for (int i = 0; i < held_count; i++) begin
                    if (held_cols[i] == j) begin
                        r.is_header   = 1'b0;
                        r.out_row     = DIM_W'(j);
                        r.out_col     = DIM_W'(held_rows[i]);
                        r.out_value   = held_vals[i];
                        r.overflow    = dropped_flag;
                        r.last_result = (k == hits);
                        transposed_q.push_back(r);
                        k++;
                    end
                end
            end
            lists_done++;
            if (dropped_flag) overflow_lists++;
            held_count = 0;
            dropped_flag = 1'b0;
        end
    endtask

    // Track register writes and input transactions, then check output transactions
    always @(posedge i_clk) begin
        int      base;
        t_result want;
        if (i_rst_n) begin
            if (cfg_we) begin
                if (cfg_index == CFG_ROW_COUNT) row_count_q = cfg_data;
                else if (cfg_index == CFG_COL_COUNT) col_count_q = cfg_data;
            end
            if (in_valid && !in_stall) begin
                base = transposed_q.size();
                predict_transpose(in_has, in_row, in_col, in_value, in_last);
                if (given_hdr_valid && in_last) transposed_q[base] = given_hdr;
            end
            if (out_valid && !out_stall) begin
                if (transposed_q.size() == 0) begin
                    $error("unexpected result: row %0d col %0d value %0d",
                           out_row, out_col, out_value);
                    error_count++;
                end else begin
                    want = transposed_q.pop_front();
                    results_checked++;
                    if (out_is_header !== want.is_header) begin
                        $error("is_header: expected %0d, got %0d", want.is_header, out_is_header);
                        error_count++;
                    end
                    if (out_row !== want.out_row) begin
                        $error("out_row: expected %0d, got %0d", want.out_row, out_row);
                        error_count++;
                    end
                    if (out_col !== want.out_col) begin
                        $error("out_col: expected %0d, got %0d", want.out_col, out_col);
                        error_count++;
                    end
                    if (out_value !== want.out_value) begin
                        $error("out_value: expected %0d, got %0d",
                               $signed(want.out_value), out_value);
                        error_count++;
                    end
                    if (out_overflow !== want.overflow) begin
                        $error("overflow: expected %0d, got %0d", want.overflow, out_overflow);
                        error_count++;
                    end
                    if (out_last !== want.last_result) begin
                        $error("last_result: expected %0d, got %0d",
                               want.last_result, out_last);
                        error_count++;
                    end
                end
            end
        end
    end

    // End the run when nothing has moved for too long
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_coordinate_list_transpose_core failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stall the result side at random, except in the calm stretch
    always @(negedge i_clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    function automatic t_result header(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows,
                                       input int count, input logic ovf, input logic last_r);
        t_result r;
        r.is_header   = 1'b1;
        r.out_row     = cols;
        r.out_col     = rows;
        r.out_value   = VAL_W'(count);
        r.overflow    = ovf;
        r.last_result = last_r;
        return r;
    endfunction

    function automatic t_step item_step(input logic has, input logic [ROW_W-1:0] row,
                                        input logic [ROW_W-1:0] col,
                                        input logic [VAL_W-1:0] value, input logic last);
        t_step s;
        s.kind      = STEP_ITEM;
        s.has       = has;
        s.row       = row;
        s.col       = col;
        s.value     = value;
        s.last      = last;
        s.reg_index = '0;
        s.reg_data  = '0;
        s.hdr_given = 1'b0;
        s.hdr       = '0;
        return s;
    endfunction

    function automatic t_step write_step(input logic [CIDX_W-1:0] idx,
                                         input logic [DIM_W-1:0] data);
        t_step s;
        s = item_step(1'b0, '0, '0, '0, 1'b0);
        s.kind      = STEP_WRITE;
        s.reg_index = idx;
        s.reg_data  = data;
        return s;
    endfunction

    function automatic t_step header_step(input logic has, input logic [ROW_W-1:0] row,
                                          input logic [ROW_W-1:0] col,
                                          input logic [VAL_W-1:0] value, input t_result hdr);
        t_step s;
        s = item_step(has, row, col, value, 1'b1);
        s.hdr_given = 1'b1;
        s.hdr       = hdr;
        return s;
    endfunction

    // Drop valid and hold off until every queued result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (transposed_q.size() != 0);
    endtask

    // Write one register once the block is idle
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        if (dirty) begin
            drain_results();
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            dirty = 1'b0;
        end
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Present one transaction, idling first at random, and hold it until taken
    task automatic push_item(input logic has, input logic [ROW_W-1:0] row,
                             input logic [ROW_W-1:0] col, input logic [VAL_W-1:0] value,
                             input logic last, input logic hdr_given, input t_result hdr);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_has   <= has;
        in_row   <= row;
        in_col   <= col;
        in_value <= value;
        in_last  <= last;
        in_valid <= 1'b1;
        given_hdr_valid = hdr_given;
        given_hdr = hdr;
        dirty = 1'b1;
        do @(posedge i_clk); while (in_stall);
        if (has || last) items_driven++;
        @(negedge i_clk);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim(input logic narrow);
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        if (roll <= 3) return DIM_W'(DEF_MAX_DIM);
        if (roll == 4) return DIM_W'(1);
        if (narrow) return DIM_W'($urandom_range(1, 8));
        return DIM_W'($urandom_range(1, DEF_MAX_DIM));
    endfunction

    initial begin
        int                 random_items;
        int                 list_no;
        int                 len;
        int                 roll;
        int                 span;
        logic [DIM_W-1:0]   new_rows;
        logic [DIM_W-1:0]   new_cols;
        logic               has;
        logic [ROW_W-1:0]   col;
        logic [VAL_W-1:0]   value;

        // directed lists: reset defaults, extremes, out-of-range indexes, ignored writes
        directed.push_back(header_step(1'b0, '0, '0, '0,
                                       header(COL_COUNT_RST, ROW_COUNT_RST, 0, 1'b0, 1'b1)));
        directed.push_back(write_step(CFG_ROW_COUNT, DIM_W'(DEF_MAX_DIM)));
        directed.push_back(write_step(CFG_COL_COUNT, DIM_W'(DEF_MAX_DIM)));
        directed.push_back(item_step(1'b1, 6'd63, 6'd63, 32'h7fff_ffff, 1'b0));
        directed.push_back(item_step(1'b1, 6'd0, 6'd0, 32'h8000_0000, 1'b0));
        directed.push_back(item_step(1'b0, 6'd63, 6'd63, 32'hffff_ffff, 1'b0));
        directed.push_back(item_step(1'b1, 6'd0, 6'd63, 32'hffff_ffff, 1'b1));
        directed.push_back(write_step(CFG_ROW_COUNT, 7'd1));
        directed.push_back(write_step(CFG_COL_COUNT, 7'd1));
        directed.push_back(item_step(1'b1, 6'd5, 6'd0, 32'd1, 1'b0));
        directed.push_back(item_step(1'b1, 6'd3, 6'd2, 32'd2, 1'b1));
        directed.push_back(write_step(CFG_COL_COUNT, 7'd0));
        directed.push_back(header_step(1'b1, 6'd1, 6'd0, 32'd7,
                                       header(7'd0, 7'd1, 1, 1'b0, 1'b1)));
        directed.push_back(write_step(CFG_ROW_COUNT, 7'd127));
        directed.push_back(write_step(CFG_COL_COUNT, 7'd127));
        directed.push_back(item_step(1'b1, 6'd2, 6'd63, 32'd9, 1'b0));
        directed.push_back(item_step(1'b1, 6'd42, 6'd21, 32'h2a2a_2a2a, 1'b0));
        directed.push_back(item_step(1'b0, 6'd21, 6'd42, 32'd0, 1'b1));
        directed.push_back(write_step(CFG_SPARE_A, 7'd127));
        directed.push_back(write_step(CFG_SPARE_B, 7'h55));
        directed.push_back(header_step(1'b1, 6'd0, 6'd0, 32'd0,
                                       header(7'd127, 7'd127, 1, 1'b0, 1'b0)));

        // hold reset, then release it
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // walk the directed table
        foreach (directed[n]) begin
            if (directed[n].kind == STEP_WRITE)
                write_reg(directed[n].reg_index, directed[n].reg_data);
            else
                push_item(directed[n].has, directed[n].row, directed[n].col, directed[n].value,
                          directed[n].last, directed[n].hdr_given, directed[n].hdr);
        end

        // random lists, new dimensions every third list
        random_items = 0;
        list_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (list_no % 3 == 0) begin
                new_rows = pick_dim(1'b0);
                new_cols = pick_dim($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 1)) begin
                    write_reg(CFG_ROW_COUNT, new_rows);
                    write_reg(CFG_COL_COUNT, new_cols);
                end else begin
                    write_reg(CFG_COL_COUNT, new_cols);
                    write_reg(CFG_ROW_COUNT, new_rows);
                end
                if ($urandom_range(0, 4) == 0)
                    write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                              DIM_W'($urandom));
            end else if ($urandom_range(0, 9) == 0) begin
                drain_results();
            end

            roll = $urandom_range(0, 19);
            if (roll <= 2) len = $urandom_range(DEF_MAX_ENTRIES + 1, DEF_MAX_ENTRIES + 8);
            else if (roll <= 4) len = 1;
            else len = $urandom_range(2, 12);

            span = (col_count_q == 0 || col_count_q > DEF_MAX_DIM) ? DEF_MAX_DIM
                                                                    : int'(col_count_q);
            for (int i = 0; i < len; i++) begin
                calm = (random_items >= CALM_FIRST) && (random_items < CALM_LAST);
                has = ($urandom_range(0, 9) != 0);
                col = ($urandom_range(0, 3) != 0) ? ROW_W'($urandom_range(0, span - 1))
                                                  : ROW_W'($urandom);
                roll = $urandom_range(0, 9);
                if (roll == 0) value = 32'h8000_0000;
                else if (roll == 1) value = 32'h7fff_ffff;
                else if (roll == 2) value = '0;
                else value = $urandom;
                push_item(has, ROW_W'($urandom), col, value, i == len - 1, 1'b0, '0);
                if (has || i == len - 1) random_items++;
            end
            list_no++;
        end
        calm = 1'b0;

        // let everything drain, then watch for stray results
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d lists (%0d with dropped entries) from %0d transactions",
                 lists_done, overflow_lists, items_driven);
        $display("checked %0d results with %0d mismatches", results_checked, error_count);
        if (error_count == 0)
            $display("tb_coordinate_list_transpose_core passed");
        else
            $display("tb_coordinate_list_transpose_core failed");
        $finish;
    end

endmodule
